FILE: sv/slm_pkg.sv
// shared types and constants for the sensor limit monitor
package slm_pkg;

  localparam int unsigned NumChannels = 20;
  localparam int unsigned ChanWidth   = 5;
  localparam int unsigned ReadWidth   = 16;
  localparam int unsigned RegWidth    = 64;
  localparam int unsigned RegIdxWidth = 4;
  localparam int unsigned EnWidth     = 2;
  localparam int unsigned PeriodWidth = 5;
  localparam int unsigned PersistWidth = 4;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  localparam logic [PersistWidth-1:0] ShutDelay = 4'd10;

  localparam logic [PeriodWidth-1:0] BlinkShutdown = 5'd10;
  localparam logic [PeriodWidth-1:0] BlinkWarning  = 5'd25;
  localparam logic [PeriodWidth-1:0] BlinkNone     = 5'd0;

  localparam logic [ReadWidth-1:0] VoltUnused  = 16'hFFFF;
  localparam logic [ReadWidth-1:0] TempMissing = 16'h8000;

  localparam logic [RegIdxWidth-1:0] RegVoltWarnHigh = 4'd0;
  localparam logic [RegIdxWidth-1:0] RegVoltShutHigh = 4'd1;
  localparam logic [RegIdxWidth-1:0] RegVoltWarnLow  = 4'd2;
  localparam logic [RegIdxWidth-1:0] RegVoltShutLow  = 4'd3;
  localparam logic [RegIdxWidth-1:0] RegBoardTemp    = 4'd4;
  localparam logic [RegIdxWidth-1:0] RegExtTemp      = 4'd5;
  localparam logic [RegIdxWidth-1:0] RegFan          = 4'd6;
  localparam logic [RegIdxWidth-1:0] RegEnables      = 4'd7;

  localparam int unsigned EnExtTemp = 0;
  localparam int unsigned EnFan     = 1;

  // classified item passed from front to back
  typedef struct packed {
    logic [NumChannels-1:0] warn;
    logic [NumChannels-1:0] shut;
    logic                   scan_end;
  } item_t;

  typedef struct packed {
    logic [RegWidth-1:0] volt_warn_high;
    logic [RegWidth-1:0] volt_shut_high;
    logic [RegWidth-1:0] volt_warn_low;
    logic [RegWidth-1:0] volt_shut_low;
    logic [RegWidth-1:0] board_temp_limits;
    logic [RegWidth-1:0] ext_temp_limits;
    logic [RegWidth-1:0] fan_limits;
    logic [EnWidth-1:0]  sensor_enables;
  } cfg_t;

  // handshake between queue and back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

FILE: sv/slm_front.sv
// front end: limit registers and per-item classification against limits
module slm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [slm_pkg::RegIdxWidth-1:0]     cfg_index_i,
  input  logic [slm_pkg::RegWidth-1:0]        cfg_data_i,
  input  logic [slm_pkg::ChanWidth-1:0]       channel_i,
  input  logic [slm_pkg::ReadWidth-1:0]       reading_i,
  input  logic                                power_off_i,
  input  logic                                scan_end_i,
  output slm_pkg::item_t                      item_o
);

  slm_pkg::cfg_t cfg_q, cfg_d;

  logic [7:0]                    wh_b, sh_b, wl_b, sl_b;
  logic [7:0]                    tw_b, ts_b, fw_b, fs_b;
  logic [slm_pkg::RegWidth-1:0]  temp_reg;
  logic [slm_pkg::ReadWidth-1:0] wh_l, sh_l, wl_l, sl_l, fw_l, fs_l;
  logic signed [slm_pkg::ReadWidth-1:0] tw_l, ts_l, t_rd;
  logic                          hit_w, hit_s;
  logic [slm_pkg::NumChannels-1:0] chan_bit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        slm_pkg::RegVoltWarnHigh: cfg_d.volt_warn_high    = cfg_data_i;
        slm_pkg::RegVoltShutHigh: cfg_d.volt_shut_high    = cfg_data_i;
        slm_pkg::RegVoltWarnLow:  cfg_d.volt_warn_low     = cfg_data_i;
        slm_pkg::RegVoltShutLow:  cfg_d.volt_shut_low     = cfg_data_i;
        slm_pkg::RegBoardTemp:    cfg_d.board_temp_limits = cfg_data_i;
        slm_pkg::RegExtTemp:      cfg_d.ext_temp_limits   = cfg_data_i;
        slm_pkg::RegFan:          cfg_d.fan_limits        = cfg_data_i;
        slm_pkg::RegEnables:
          cfg_d.sensor_enables = cfg_data_i[slm_pkg::EnWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // limit selection
  always_comb begin
    wh_b = cfg_q.volt_warn_high[{channel_i[2:0], 3'b000} +: 8];
    sh_b = cfg_q.volt_shut_high[{channel_i[2:0], 3'b000} +: 8];
    wl_b = cfg_q.volt_warn_low[{channel_i[2:0], 3'b000} +: 8];
    sl_b = cfg_q.volt_shut_low[{channel_i[2:0], 3'b000} +: 8];
    temp_reg = (channel_i[4:2] == 3'd2) ? cfg_q.board_temp_limits : cfg_q.ext_temp_limits;
    tw_b = temp_reg[{1'b0, channel_i[1:0], 3'b000} +: 8];
    ts_b = temp_reg[{1'b1, channel_i[1:0], 3'b000} +: 8];
    fw_b = cfg_q.fan_limits[{1'b0, channel_i[1:0], 3'b000} +: 8];
    fs_b = cfg_q.fan_limits[{1'b1, channel_i[1:0], 3'b000} +: 8];
    wh_l = {4'b0000, wh_b, 4'b0000};
    sh_l = {4'b0000, sh_b, 4'b0000};
    wl_l = {4'b0000, wl_b, 4'b0000};
    sl_l = {4'b0000, sl_b, 4'b0000};
    fw_l = {4'b0000, fw_b, 4'b0000};
    fs_l = {4'b0000, fs_b, 4'b0000};
    tw_l = $signed({tw_b, 8'h00});
    ts_l = $signed({ts_b, 8'h00});
    t_rd = $signed(reading_i);
  end

  // classification
  always_comb begin
    hit_w = 1'b0;
    hit_s = 1'b0;
    case (channel_i) inside
      [5'd0:5'd7]: begin
        if (reading_i != slm_pkg::VoltUnused && !(channel_i < 5'd6 && power_off_i)) begin
          hit_w = (wh_b != 8'd0 && reading_i > wh_l) || (wl_b != 8'd0 && reading_i < wl_l);
          hit_s = (sh_b != 8'd0 && reading_i > sh_l) || (sl_b != 8'd0 && reading_i < sl_l);
        end
      end
      [5'd8:5'd15]: begin
        if (reading_i != slm_pkg::TempMissing &&
            (channel_i < 5'd12 || cfg_q.sensor_enables[slm_pkg::EnExtTemp])) begin
          hit_w = (tw_b != 8'd0) && (t_rd > tw_l);
          hit_s = (ts_b != 8'd0) && (t_rd > ts_l);
        end
      end
      [5'd16:5'd19]: begin
        if (cfg_q.sensor_enables[slm_pkg::EnFan]) begin
          hit_w = (fw_b != 8'd0) && (reading_i < fw_l);
          hit_s = (fs_b != 8'd0) && (reading_i < fs_l);
        end
      end
      default: ;
    endcase
  end

  assign chan_bit        = slm_pkg::NumChannels'(1) << channel_i;
  assign item_o.warn     = hit_w ? chan_bit : '0;
  assign item_o.shut     = hit_s ? chan_bit : '0;
  assign item_o.scan_end = scan_end_i;

endmodule

FILE: sv/slm_fifo.sv
// short queue of classified items between front and back end
module slm_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slm_pkg::item_t   item_i,
  output logic             full_o,
  input  logic             pop_i,
  output slm_pkg::q_out_t  head_o
);

  slm_pkg::item_t entries_q [slm_pkg::QueueDepth];

  logic [slm_pkg::QueueAw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [slm_pkg::QueueCw-1:0] count_q, count_d;
  logic                        do_push, do_pop;

  assign full_o       = (count_q == slm_pkg::QueueCw'(slm_pkg::QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: sv/slm_back.sv
// back end: scan accumulation, shutdown persistence and latch, result register
module slm_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  slm_pkg::q_out_t                    head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [slm_pkg::NumChannels-1:0]    warning_mask_o,
  output logic [slm_pkg::NumChannels-1:0]    shutdown_mask_o,
  output logic                               shut_taken_o,
  output logic [slm_pkg::PeriodWidth-1:0]    blink_period_o
);

  logic [slm_pkg::NumChannels-1:0]  acc_w_q, acc_w_d, acc_s_q, acc_s_d;
  logic [slm_pkg::NumChannels-1:0]  latch_q, latch_d;
  logic [slm_pkg::PersistWidth-1:0] persist_q, persist_d;
  logic                             out_valid_q, out_valid_d;
  logic [slm_pkg::NumChannels-1:0]  warn_q, warn_d, smask_q, smask_d;
  logic                             took_q, took_d;
  logic [slm_pkg::PeriodWidth-1:0]  period_q, period_d;
  logic [slm_pkg::NumChannels-1:0]  warn_all, shut_all;
  logic                             out_free, finish;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_i.valid && (!head_i.item.scan_end || out_free);
  assign finish   = pop_o && head_i.item.scan_end;
  assign warn_all = acc_w_q | head_i.item.warn;
  assign shut_all = acc_s_q | head_i.item.shut;

  always_comb begin
    acc_w_d     = acc_w_q;
    acc_s_d     = acc_s_q;
    latch_d     = latch_q;
    persist_d   = persist_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    warn_d      = warn_q;
    smask_d     = smask_q;
    took_d      = took_q;
    period_d    = period_q;
    if (pop_o) begin
      acc_w_d = warn_all;
      acc_s_d = shut_all;
    end
    if (finish) begin
      acc_w_d = '0;
      acc_s_d = '0;
      took_d  = 1'b0;
      if (shut_all != '0 && latch_q == '0) begin
        if (persist_q >= slm_pkg::ShutDelay) begin
          latch_d   = shut_all;
          persist_d = '0;
          took_d    = 1'b1;
        end else begin
          persist_d = persist_q + 1'b1;
        end
      end else begin
        persist_d = '0;
      end
      out_valid_d = 1'b1;
      warn_d      = warn_all;
      smask_d     = latch_d;
      if (latch_d != '0) begin
        period_d = slm_pkg::BlinkShutdown;
      end else if (warn_all != '0) begin
        period_d = slm_pkg::BlinkWarning;
      end else begin
        period_d = slm_pkg::BlinkNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_w_q     <= '0;
      acc_s_q     <= '0;
      latch_q     <= '0;
      persist_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_w_q     <= acc_w_d;
      acc_s_q     <= acc_s_d;
      latch_q     <= latch_d;
      persist_q   <= persist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    warn_q   <= warn_d;
    smask_q  <= smask_d;
    took_q   <= took_d;
    period_q <= period_d;
  end

  assign out_valid_o     = out_valid_q;
  assign warning_mask_o  = warn_q;
  assign shutdown_mask_o = smask_q;
  assign shut_taken_o    = took_q;
  assign blink_period_o  = period_q;

endmodule

FILE: sv/sensor_limit_monitor.sv
// top level of the sensor limit monitor
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_stall_o    | channel_i, reading_i, power_off_i, scan_end_i
//  out     | out_valid_o / out_stall_i  | warning_mask_o, shutdown_mask_o,
//          |                            | shut_taken_o, blink_period_o
//
// one item per cycle while in_stall_o is low; each item is classified in the cycle
// it is taken and queued; a scan result is registered when its scan end item pops.
// a four-entry queue parts front and back; in_stall_o rises only when it is full.
// the back end holds on a scan end item while the result register is stalled.
// reset clears limits, scan masks, persistence count and the shutdown latch.
module sensor_limit_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [slm_pkg::RegIdxWidth-1:0]   cfg_index_i,
  input  logic [slm_pkg::RegWidth-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [slm_pkg::ChanWidth-1:0]     channel_i,
  input  logic [slm_pkg::ReadWidth-1:0]     reading_i,
  input  logic                              power_off_i,
  input  logic                              scan_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [slm_pkg::NumChannels-1:0]   warning_mask_o,
  output logic [slm_pkg::NumChannels-1:0]   shutdown_mask_o,
  output logic                              shut_taken_o,
  output logic [slm_pkg::PeriodWidth-1:0]   blink_period_o
);

  slm_pkg::item_t  item;
  slm_pkg::q_out_t head;
  logic            q_full, q_pop;

  slm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .channel_i   (channel_i),
    .reading_i   (reading_i),
    .power_off_i (power_off_i),
    .scan_end_i  (scan_end_i),
    .item_o      (item)
  );

  slm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (head)
  );

  slm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .warning_mask_o  (warning_mask_o),
    .shutdown_mask_o (shutdown_mask_o),
    .shut_taken_o    (shut_taken_o),
    .blink_period_o  (blink_period_o)
  );

  assign in_stall_o = q_full;

endmodule

FILE: sv/slm_checker.sv
// port-level checks for the sensor limit monitor and their binding
module slm_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [slm_pkg::NumChannels-1:0]   warning_mask_o,
  input  logic [slm_pkg::NumChannels-1:0]   shutdown_mask_o,
  input  logic                              shut_taken_o,
  input  logic [slm_pkg::PeriodWidth-1:0]   blink_period_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(warning_mask_o) && $stable(shutdown_mask_o) && $stable(blink_period_o) &&
      $stable(shut_taken_o))
    else $error("stalled result changed");

  a_period_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (blink_period_o == slm_pkg::BlinkShutdown ||
                     blink_period_o == slm_pkg::BlinkWarning ||
                     blink_period_o == slm_pkg::BlinkNone))
    else $error("bad blink period");

  a_latch_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((shutdown_mask_o != '0) == (blink_period_o == slm_pkg::BlinkShutdown)))
    else $error("blink period disagrees with shutdown latch");

  a_took_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shut_taken_o |-> shutdown_mask_o != '0)
    else $error("power shutdown without latched mask");

endmodule

bind sensor_limit_monitor slm_checker u_slm_checker (.*);
